[src/loi_pkg.sv]
// ----------------------------------------------------------------------------
// loi_pkg
// Shared types, codes and helpers for the line offset indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package loi_pkg;

  localparam int DEFAULT_TABLE_DEPTH    = 1024;
  localparam int DEFAULT_POSITION_WIDTH = 32;

  // fixed field widths of the item ports
  localparam int BYTE_W      = 8;
  localparam int LINE_NUM_W  = 16;
  localparam int OUT_POS_W   = 32;
  localparam int OUT_COUNT_W = 11;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;
  localparam logic [BYTE_W-1:0] TAB_BYTE     = 8'h09;
  localparam logic [BYTE_W-1:0] CR_BYTE      = 8'h0D;

  localparam logic OP_TEXT  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_FOUND = 1'b0;
  localparam logic STATUS_MISS  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } loi_state_t;

  typedef struct packed {
    logic byte_en;   // text item accepted
    logic query_en;  // query item accepted, table read launched
    logic capture;   // table read data valid, load the result register
  } loi_cmd_t;

  // tab through carriage return, and space; newline is caught before this
  function automatic logic is_blank(input logic [BYTE_W-1:0] c);
    is_blank = (c == SPACE_BYTE) || ((c >= TAB_BYTE) && (c <= CR_BYTE));
  endfunction

endpackage

`default_nettype wire

[src/loi_ram.sv]
// ----------------------------------------------------------------------------
// loi_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module loi_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/loi_ctrl.sv]
// ----------------------------------------------------------------------------
// loi_ctrl
// Handshake control: input stall, table read sequencing, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module loi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              opcode,
  input  wire logic              out_stall,
  output logic                   in_stall,
  output logic                   out_valid,
  output loi_pkg::loi_cmd_t      cmd
);
  import loi_pkg::*;

  loi_state_t state, state_next;
  logic       accept;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a query needs the result register free by the time its read data lands
  assign in_stall = (state == ST_READ) ||
                    ((opcode == OP_QUERY) && out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_QUERY)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.byte_en    = accept && (opcode == OP_TEXT);
    cmd.query_en   = accept && (opcode == OP_QUERY);
    cmd.capture    = (state == ST_READ);
    out_valid_next = out_valid;
    if (cmd.capture) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

[src/loi_datapath.sv]
// ----------------------------------------------------------------------------
// loi_datapath
// Line tracking registers, line table and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module loi_datapath #(
  parameter int TABLE_DEPTH    = loi_pkg::DEFAULT_TABLE_DEPTH,
  parameter int POSITION_WIDTH = loi_pkg::DEFAULT_POSITION_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire loi_pkg::loi_cmd_t                 cmd,
  input  wire logic [loi_pkg::BYTE_W-1:0]        text_byte,
  input  wire logic [loi_pkg::LINE_NUM_W-1:0]    line_number,
  output logic                                   status,
  output logic      [loi_pkg::OUT_POS_W-1:0]     line_start,
  output logic      [loi_pkg::OUT_POS_W-1:0]     line_bytes,
  output logic      [loi_pkg::OUT_COUNT_W-1:0]   lines_recorded,
  output logic                                   table_overflow
);
  import loi_pkg::*;

  localparam int PW = POSITION_WIDTH;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW = LINE_NUM_W + 1;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  logic [CW-1:0] entry_count, entry_count_next;
  logic [PW-1:0] next_start, next_start_next;
  logic [PW-1:0] cur_len, cur_len_next;
  logic          inside_line, inside_line_next;
  logic          dropped, dropped_next;
  logic          miss;

  logic [PW:0]     len_sum, start_inc_sum, start_add_sum;
  logic [PW-1:0]   len_inc, start_inc, start_add;
  logic            is_newline, table_full;
  logic            wr_en;
  logic [LINE_NUM_W-1:0] line_m1;
  logic [2*PW-1:0] rd_data;
  logic            query_miss;

  // saturating increments and the end-of-line advance
  assign len_sum       = {1'b0, cur_len} + (PW + 1)'(1);
  assign len_inc       = len_sum[PW] ? '1 : len_sum[PW-1:0];
  assign start_inc_sum = {1'b0, next_start} + (PW + 1)'(1);
  assign start_inc     = start_inc_sum[PW] ? '1 : start_inc_sum[PW-1:0];
  assign start_add_sum = {1'b0, next_start} + {1'b0, len_inc};
  assign start_add     = start_add_sum[PW] ? '1 : start_add_sum[PW-1:0];

  assign is_newline = (text_byte == NEWLINE_BYTE);
  assign table_full = (entry_count == FULL_COUNT);
  assign wr_en      = cmd.byte_en && is_newline && !table_full;

  always_comb begin
    entry_count_next = entry_count;
    next_start_next  = next_start;
    cur_len_next     = cur_len;
    inside_line_next = inside_line;
    dropped_next     = dropped;
    if (cmd.byte_en) begin
      if (is_newline) begin
        inside_line_next = 1'b0;
        if (table_full) begin
          dropped_next = 1'b1;
        end else begin
          entry_count_next = entry_count + CW'(1);
        end
        next_start_next = start_add;
        cur_len_next    = '0;
      end else if (is_blank(text_byte) && !inside_line) begin
        next_start_next = start_inc;
      end else begin
        inside_line_next = 1'b1;
        cur_len_next     = len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      next_start  <= '0;
      cur_len     <= '0;
      inside_line <= 1'b0;
      dropped     <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      next_start  <= next_start_next;
      cur_len     <= cur_len_next;
      inside_line <= inside_line_next;
      dropped     <= dropped_next;
    end
  end

  assign line_m1    = line_number - LINE_NUM_W'(1);
  assign query_miss = (line_number == '0) || (LW'(line_number) > LW'(entry_count));

  loi_ram #(
    .WIDTH  (2 * PW),
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[AW-1:0]),
    .wr_data ({len_inc, next_start}),
    .rd_en   (cmd.query_en),
    .rd_addr (line_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  // miss flag rides alongside the table read
  always_ff @(posedge clk) begin
    if (cmd.query_en) begin
      miss <= query_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status         <= miss ? STATUS_MISS : STATUS_FOUND;
      line_start     <= miss ? '0 : OUT_POS_W'(rd_data[PW-1:0]);
      line_bytes     <= miss ? '0 : OUT_POS_W'(rd_data[2*PW-1:PW]);
      lines_recorded <= OUT_COUNT_W'(entry_count);
      table_overflow <= dropped;
    end
  end

endmodule

`default_nettype wire

[src/line_offset_indexer.sv]
// ----------------------------------------------------------------------------
// line_offset_indexer
// Text items may arrive back to back, also while a result waits, but not
// while a query's table read is in flight. A query passes through accept,
// table read (registered RAM port) and result register, in that order.
// Synchronous reset clears the line counters and flags; the table contents
// are not cleared, only entries below the line count reach the outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module line_offset_indexer #(
  parameter int TABLE_DEPTH    = loi_pkg::DEFAULT_TABLE_DEPTH,
  parameter int POSITION_WIDTH = loi_pkg::DEFAULT_POSITION_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              opcode,
  input  wire logic [loi_pkg::BYTE_W-1:0]        text_byte,
  input  wire logic [loi_pkg::LINE_NUM_W-1:0]    line_number,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   status,
  output logic      [loi_pkg::OUT_POS_W-1:0]     line_start,
  output logic      [loi_pkg::OUT_POS_W-1:0]     line_bytes,
  output logic      [loi_pkg::OUT_COUNT_W-1:0]   lines_recorded,
  output logic                                   table_overflow
);
  import loi_pkg::*;

  loi_cmd_t cmd;

  loi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  loi_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .text_byte      (text_byte),
    .line_number    (line_number),
    .status         (status),
    .line_start     (line_start),
    .line_bytes     (line_bytes),
    .lines_recorded (lines_recorded),
    .table_overflow (table_overflow)
  );

endmodule

`default_nettype wire

[src/loi_checker.sv]
// ----------------------------------------------------------------------------
// loi_checker
// Port-level checks on query timing and result contents, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module loi_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              opcode,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              status,
  input wire logic [loi_pkg::OUT_POS_W-1:0]     line_start,
  input wire logic [loi_pkg::OUT_POS_W-1:0]     line_bytes,
  input wire logic [loi_pkg::OUT_COUNT_W-1:0]   lines_recorded,
  input wire logic                              table_overflow
);
  import loi_pkg::*;

  logic query_acc;
  assign query_acc = in_valid && !in_stall && (opcode == OP_QUERY);

  // a query item's result stays invalid during the table read, then appears as the result register loads
  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> !out_valid ##1 out_valid)
    else $error("query result not on time");

  // nothing else is taken while the table read is in flight
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> in_stall)
    else $error("input accepted during table read");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_MISS)) |-> (line_start == '0) && (line_bytes == '0))
    else $error("miss result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status) && $stable(line_start)
      && $stable(line_bytes) && $stable(lines_recorded) && $stable(table_overflow))
    else $error("stalled result changed");

endmodule

bind line_offset_indexer loi_checker u_loi_checker (.*);

`default_nettype wire
